// ----- hdl/ptob_pkg.sv -----
// Shared types, codes and defaults for the price-time order book.
// No dependencies; every other file of the block imports it.
package ptob_pkg;

    localparam int DefPriceLevels = 64;
    localparam int DefLevelDepth  = 16;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_SHOW   = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SHOW   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        side;
        logic [31:0] price;
        logic [31:0] handle;
    } t_cmd;

endpackage

// ----- hdl/ptob_front.sv -----
// Front end: takes requests, classifies the function code and queues them.
// Depends on ptob_pkg.
module ptob_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [1:0]      i_func,
    input  logic            i_side,
    input  logic [31:0]     i_price,
    input  logic [31:0]     i_order_handle,
    input  logic            i_pop,
    output logic            o_cmd_valid,
    output ptob_pkg::t_cmd  o_cmd
);
    import ptob_pkg::*;

    t_cmd       r_q [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       r_ready;
    logic       w_push;
    t_cmd       w_cmd;

    always_comb begin
        w_cmd.side   = i_side;
        w_cmd.price  = i_price;
        w_cmd.handle = i_order_handle;
        unique case (i_func)
            FUNC_ADD:    w_cmd.op = OP_ADD;
            FUNC_REMOVE: w_cmd.op = OP_REMOVE;
            FUNC_SHOW:   w_cmd.op = OP_SHOW;
            default:     w_cmd.op = OP_NOP;
        endcase
    end

    assign busy        = !r_ready || (r_cnt == 2'd2);
    assign w_push      = start && !busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_cnt   <= 2'd0;
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            if (w_push) begin
                r_q[r_wptr] <= w_cmd;
                r_wptr      <= !r_wptr;
            end
            if (i_pop && o_cmd_valid) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop && o_cmd_valid);
        end
    end

endmodule

// ----- hdl/ptob_side.sv -----
// One side of the book: a sorted chain of level cells, best level first,
// each naming a region of the order memory. Depends on ptob_pkg.
module ptob_side #(
    parameter int LEVELS = ptob_pkg::DefPriceLevels,
    parameter int DEPTH  = ptob_pkg::DefLevelDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sell,
    input  logic              i_exec,
    input  ptob_pkg::t_op     i_op,
    input  logic [31:0]       i_price,
    input  logic [31:0]       i_handle,
    output logic [1:0]        o_status,
    output logic [31:0]       o_rd_data,
    output logic [31:0]       o_best_price,
    output logic              o_empty
);
    import ptob_pkg::*;

    localparam int ID_W   = $clog2(LEVELS);
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int EXT_W  = CNT_W + 1;
    localparam int ADDR_W = $clog2(LEVELS * DEPTH);

    logic [31:0]    r_price [LEVELS];
    logic [CNT_W-1:0] r_count [LEVELS];
    logic [PTR_W-1:0] r_head [LEVELS];
    logic [ID_W-1:0]  r_id [LEVELS];
    logic [31:0]    n_price [LEVELS];
    logic [CNT_W-1:0] n_count [LEVELS];
    logic [PTR_W-1:0] n_head [LEVELS];
    logic [ID_W-1:0]  n_id [LEVELS];

    logic [31:0]    r_store [LEVELS * DEPTH];
    logic [31:0]    r_rd;

    logic [LEVELS-1:0] w_active, w_hit, w_ins, w_first;
    logic              w_hit_any;
    logic [ID_W-1:0]   w_sel_id;
    logic [PTR_W-1:0]  w_sel_head, w_sel_head_nx, w_tail;
    logic [CNT_W-1:0]  w_sel_cnt;
    logic [EXT_W-1:0]  w_tsum;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic              w_we;

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            w_active[i] = (r_count[i] != '0);
            w_hit[i]    = w_active[i] && (r_price[i] == i_price);
            w_ins[i]    = !w_active[i] ||
                          (i_sell ? (i_price < r_price[i]) : (i_price > r_price[i]));
        end
        // the insert mask is a thermometer; its first set bit is the new slot
        w_first = w_ins & ~{w_ins[LEVELS-2:0], 1'b0};
        w_hit_any  = |w_hit;
        w_sel_id   = '0;
        w_sel_head = '0;
        w_sel_cnt  = '0;
        for (int i = 0; i < LEVELS; i++) begin
            w_sel_id   = w_sel_id   | (w_hit[i] ? r_id[i]    : '0);
            w_sel_head = w_sel_head | (w_hit[i] ? r_head[i]  : '0);
            w_sel_cnt  = w_sel_cnt  | (w_hit[i] ? r_count[i] : '0);
        end
        w_tsum = EXT_W'(w_sel_head) + EXT_W'(w_sel_cnt);
        if (w_tsum >= EXT_W'(DEPTH)) begin
            w_tsum = w_tsum - EXT_W'(DEPTH);
        end
        w_tail = PTR_W'(w_tsum);
        w_sel_head_nx = (r_head[0] == PTR_W'(DEPTH - 1)) ? '0 : r_head[0] + 1'b1;
    end

    always_comb begin
        unique case (i_op)
            OP_ADD: begin
                if (w_hit_any) begin
                    o_status = (w_sel_cnt == CNT_W'(DEPTH)) ? ST_FULL : ST_DONE;
                end else begin
                    o_status = w_active[LEVELS-1] ? ST_FULL : ST_DONE;
                end
            end
            OP_REMOVE: o_status = w_active[0] ? ST_DONE : ST_NONE;
            OP_SHOW:   o_status = w_hit_any ? ST_DONE : ST_NONE;
            default:   o_status = ST_NONE;
        endcase
    end

    assign w_we    = i_exec && (i_op == OP_ADD) && (o_status == ST_DONE);
    assign w_waddr = w_hit_any
        ? ADDR_W'(w_sel_id) * ADDR_W'(DEPTH) + ADDR_W'(w_tail)
        : ADDR_W'(r_id[LEVELS-1]) * ADDR_W'(DEPTH);
    assign w_raddr = ADDR_W'(w_sel_id) * ADDR_W'(DEPTH) + ADDR_W'(w_sel_head);

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            n_price[i] = r_price[i];
            n_count[i] = r_count[i];
            n_head[i]  = r_head[i];
            n_id[i]    = r_id[i];
        end
        if (i_exec && i_op == OP_ADD && o_status == ST_DONE) begin
            if (w_hit_any) begin
                for (int i = 0; i < LEVELS; i++) begin
                    if (w_hit[i]) begin
                        n_count[i] = r_count[i] + 1'b1;
                    end
                end
            end else begin
                // open a level: cells from the new slot down move one place
                for (int i = 1; i < LEVELS; i++) begin
                    if (w_ins[i] && !w_first[i]) begin
                        n_price[i] = r_price[i-1];
                        n_count[i] = r_count[i-1];
                        n_head[i]  = r_head[i-1];
                        n_id[i]    = r_id[i-1];
                    end
                end
                for (int i = 0; i < LEVELS; i++) begin
                    if (w_first[i]) begin
                        n_price[i] = i_price;
                        n_count[i] = CNT_W'(1);
                        n_head[i]  = '0;
                        n_id[i]    = r_id[LEVELS-1];
                    end
                end
            end
        end else if (i_exec && i_op == OP_REMOVE && w_active[0]) begin
            if (r_count[0] == CNT_W'(1)) begin
                // best level drained: close it and pull the chain up
                for (int i = 0; i < LEVELS - 1; i++) begin
                    n_price[i] = r_price[i+1];
                    n_count[i] = r_count[i+1];
                    n_head[i]  = r_head[i+1];
                    n_id[i]    = r_id[i+1];
                end
                n_count[LEVELS-1] = '0;
                n_head[LEVELS-1]  = '0;
                n_id[LEVELS-1]    = r_id[0];
            end else begin
                n_count[0] = r_count[0] - 1'b1;
                n_head[0]  = w_sel_head_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_count[i] <= '0;
                r_head[i]  <= '0;
                r_id[i]    <= ID_W'(i);
            end
        end else begin
            for (int i = 0; i < LEVELS; i++) begin
                r_count[i] <= n_count[i];
                r_head[i]  <= n_head[i];
                r_id[i]    <= n_id[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LEVELS; i++) begin
            r_price[i] <= n_price[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= i_handle;
        end
        r_rd <= r_store[w_raddr];
    end

    assign o_rd_data    = r_rd;
    assign o_empty      = !w_active[0];
    assign o_best_price = w_active[0] ? r_price[0] : (i_sell ? '1 : '0);

endmodule

// ----- hdl/price_time_order_book.sv -----
// Top level of the price-time order book: front queue, back sequencer, two sides.
// Depends on ptob_pkg, ptob_front and ptob_side.
//
// A request is taken when start is high and busy low; a two-entry queue lets
// requests arrive while the back end works. Each request goes through S_EXEC
// (search and update the level chain, address the order memory), then S_RESP
// (the registered memory read); the back end takes no new request before it is
// back in S_EXEC. Each result appears for exactly one cycle with o_valid
// high and cannot be held off. The best prices and empty flags show the book
// after the request. Level and order storage needs no clearing after reset.
module price_time_order_book #(
    parameter int PRICE_LEVELS = ptob_pkg::DefPriceLevels,
    parameter int LEVEL_DEPTH  = ptob_pkg::DefLevelDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic        i_side,
    input  logic [31:0] i_price,
    input  logic [31:0] i_order_handle,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_front_handle,
    output logic [31:0] o_best_buy_price,
    output logic [31:0] o_best_sell_price,
    output logic        o_buy_empty,
    output logic        o_sell_empty
);
    import ptob_pkg::*;

    typedef enum logic [1:0] {
        S_EXEC = 2'b01,
        S_RESP = 2'b10
    } t_state;

    t_state     r_state;
    logic       w_cmd_valid, w_go;
    t_cmd       w_cmd;
    logic [1:0] w_bid_status, w_ask_status;
    logic [31:0] w_bid_rd, w_ask_rd;
    logic [1:0] r_status;
    logic       r_show, r_side;

    ptob_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_side         (i_side),
        .i_price        (i_price),
        .i_order_handle (i_order_handle),
        .i_pop          (w_go),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd)
    );

    assign w_go = (r_state == S_EXEC) && w_cmd_valid;

    ptob_side #(.LEVELS(PRICE_LEVELS), .DEPTH(LEVEL_DEPTH)) u_bid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sell       (1'b0),
        .i_exec       (w_go && !w_cmd.side),
        .i_op         (w_cmd.op),
        .i_price      (w_cmd.price),
        .i_handle     (w_cmd.handle),
        .o_status     (w_bid_status),
        .o_rd_data    (w_bid_rd),
        .o_best_price (o_best_buy_price),
        .o_empty      (o_buy_empty)
    );

    ptob_side #(.LEVELS(PRICE_LEVELS), .DEPTH(LEVEL_DEPTH)) u_ask (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sell       (1'b1),
        .i_exec       (w_go && w_cmd.side),
        .i_op         (w_cmd.op),
        .i_price      (w_cmd.price),
        .i_handle     (w_cmd.handle),
        .o_status     (w_ask_status),
        .o_rd_data    (w_ask_rd),
        .o_best_price (o_best_sell_price),
        .o_empty      (o_sell_empty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EXEC;
        end else begin
            unique case (r_state)
                S_EXEC:  r_state <= w_go ? S_RESP : S_EXEC;
                S_RESP:  r_state <= S_EXEC;
                default: r_state <= S_EXEC;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_status <= w_cmd.side ? w_ask_status : w_bid_status;
            r_show   <= (w_cmd.op == OP_SHOW);
            r_side   <= w_cmd.side;
        end
    end

    assign o_valid        = (r_state == S_RESP);
    assign o_status       = r_status;
    assign o_front_handle = (r_show && r_status == ST_DONE)
                          ? (r_side ? w_ask_rd : w_bid_rd) : '0;

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_bid_empty_price: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_buy_empty |-> (o_best_buy_price == '0))
        else $error("empty buy side reports a price");

    a_ask_empty_price: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sell_empty |-> (o_best_sell_price == '1))
        else $error("empty sell side reports a price");

    a_result_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> o_valid)
        else $error("queued request produced no result");

endmodule

// ----- tb/tb_price_time_order_book.sv -----
`timescale 1ns / 100ps
// Self-checking bench for price_time_order_book: directed table, fills, random requests.
// Depends on ptob_pkg and the block itself; predicts each result with a behavioural book.
module tb_price_time_order_book;
    import ptob_pkg::*;

    localparam int NLEV = DefPriceLevels;
    localparam int NDEP = DefLevelDepth;
    localparam int RAND_REQS = 1770;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] front;
        logic [31:0] best_buy;
        logic [31:0] best_sell;
        logic        buy_empty;
        logic        sell_empty;
    } t_res;

    typedef struct {
        t_op         op;
        logic        side;
        logic [31:0] price;
        logic [31:0] handle;
        logic        typed;
        logic [1:0]  status;
        logic [31:0] front;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_func;
    logic        i_side;
    logic [31:0] i_price;
    logic [31:0] i_order_handle;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [31:0] o_front_handle;
    logic [31:0] o_best_buy_price;
    logic [31:0] o_best_sell_price;
    logic        o_buy_empty;
    logic        o_sell_empty;

    // Book state per side: index 0 buy, 1 sell.
    logic [31:0] lvl_price [2][NLEV];
    int          lvl_count [2][NLEV];
    int          lvl_head  [2][NLEV];
    logic [31:0] order_mem [2][NLEV*NDEP];

    t_res        pending_results[$];
    logic [1:0]  typed_status[$];
    logic [31:0] typed_front[$];
    logic        typed_flag[$];
    int          errors;
    int          results_seen;
    int          cycles;
    int          send_idle_pct;
    logic [31:0] used_prices[2][$];

    price_time_order_book u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_side(i_side), .i_price(i_price),
        .i_order_handle(i_order_handle), .o_valid(o_valid), .o_status(o_status),
        .o_front_handle(o_front_handle), .o_best_buy_price(o_best_buy_price),
        .o_best_sell_price(o_best_sell_price), .o_buy_empty(o_buy_empty),
        .o_sell_empty(o_sell_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int find_level(input logic s, input logic [31:0] p);
        for (int i = 0; i < NLEV; i++)
            if (lvl_count[s][i] != 0 && lvl_price[s][i] == p) return i;
        return NLEV;
    endfunction

    function automatic int best_level(input logic s);
        int b;
        b = NLEV;
        for (int i = 0; i < NLEV; i++) begin
            if (lvl_count[s][i] == 0) continue;
            if (b == NLEV || (s == 1'b0 ? lvl_price[s][i] > lvl_price[s][b]
                                        : lvl_price[s][i] < lvl_price[s][b]))
                b = i;
        end
        return b;
    endfunction

    function automatic t_res book_apply(input t_op op, input logic s,
                                        input logic [31:0] p, input logic [31:0] h);
        t_res r;
        int   k;
        r = '0;
        r.status = ST_NONE;
        case (op)
            OP_ADD: begin
                k = find_level(s, p);
                if (k == NLEV) begin
                    for (k = 0; k < NLEV; k++) if (lvl_count[s][k] == 0) break;
                    if (k < NLEV) begin
                        lvl_price[s][k] = p;
                        lvl_head[s][k] = 0;
                    end
                end
                if (k == NLEV || lvl_count[s][k] >= NDEP) begin
                    r.status = ST_FULL;
                end else begin
                    order_mem[s][k*NDEP + (lvl_head[s][k] + lvl_count[s][k]) % NDEP] = h;
                    lvl_count[s][k]++;
                    r.status = ST_DONE;
                end
            end
            OP_REMOVE: begin
                k = best_level(s);
                if (k != NLEV) begin
                    lvl_count[s][k]--;
                    if (lvl_count[s][k] == 0) lvl_head[s][k] = 0;
                    else lvl_head[s][k] = (lvl_head[s][k] + 1) % NDEP;
                    r.status = ST_DONE;
                end
            end
            OP_SHOW: begin
                k = find_level(s, p);
                if (k != NLEV) begin
                    r.front = order_mem[s][k*NDEP + lvl_head[s][k]];
                    r.status = ST_DONE;
                end
            end
            default: ;
        endcase
        k = best_level(1'b0);
        r.best_buy = (k == NLEV) ? 32'd0 : lvl_price[0][k];
        r.buy_empty = (k == NLEV);
        k = best_level(1'b1);
        r.best_sell = (k == NLEV) ? 32'hFFFF_FFFF : lvl_price[1][k];
        r.sell_empty = (k == NLEV);
        return r;
    endfunction

    // Drive one request at the falling edge and hold it until accepted.
    // Start stays high afterwards; the next request or an idle cycle sets it.
    task automatic send_request(input t_op op, input logic s, input logic [31:0] p,
                                input logic [31:0] h, input logic tf,
                                input logic [1:0] ts, input logic [31:0] tfr);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_func <= op;
        i_side <= s;
        i_price <= p;
        i_order_handle <= h;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(book_apply(op, s, p, h));
        typed_flag.push_back(tf);
        typed_status.push_back(ts);
        typed_front.push_back(tfr);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_res exp_r;
        logic tf;
        logic [1:0] ts;
        logic [31:0] tfr;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding, status %0d", $time,
                         o_status);
            end else begin
                exp_r = pending_results.pop_front();
                tf = typed_flag.pop_front();
                ts = typed_status.pop_front();
                tfr = typed_front.pop_front();
                if (tf && (ts != exp_r.status || tfr != exp_r.front)) begin
                    errors++;
                    $display("%0t: table row disagrees with book: %0d/%h vs %0d/%h",
                             $time, ts, tfr, exp_r.status, exp_r.front);
                end
                if (o_status != exp_r.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, o_status);
                end
                if (o_front_handle != exp_r.front) begin
                    errors++;
                    $display("%0t: front handle expected %h actual %h", $time,
                             exp_r.front, o_front_handle);
                end
                if (o_best_buy_price != exp_r.best_buy) begin
                    errors++;
                    $display("%0t: best buy expected %h actual %h", $time,
                             exp_r.best_buy, o_best_buy_price);
                end
                if (o_best_sell_price != exp_r.best_sell) begin
                    errors++;
                    $display("%0t: best sell expected %h actual %h", $time,
                             exp_r.best_sell, o_best_sell_price);
                end
                if (o_buy_empty != exp_r.buy_empty) begin
                    errors++;
                    $display("%0t: buy empty expected %0b actual %0b", $time,
                             exp_r.buy_empty, o_buy_empty);
                end
                if (o_sell_empty != exp_r.sell_empty) begin
                    errors++;
                    $display("%0t: sell empty expected %0b actual %0b", $time,
                             exp_r.sell_empty, o_sell_empty);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [31:0] pick_price(input logic s);
        // Mostly reuse a small set of prices so levels fill and empty.
        if (used_prices[s].size() > 0 && $urandom_range(99) < 70)
            return used_prices[s][$urandom_range(used_prices[s].size() - 1)];
        return ($urandom_range(9) == 0) ? $urandom : 32'd1000 + $urandom_range(90);
    endfunction

    t_row table_rows[] = '{
        '{OP_REMOVE, 1'b0, 32'd0, 32'd0, 1'b1, ST_NONE, 32'd0},
        '{OP_REMOVE, 1'b1, 32'd0, 32'd0, 1'b1, ST_NONE, 32'd0},
        '{OP_SHOW, 1'b0, 32'd5, 32'd0, 1'b1, ST_NONE, 32'd0},
        '{OP_NOP, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_NONE, 32'd0},
        '{OP_ADD, 1'b0, 32'd0, 32'h0000_0000, 1'b1, ST_DONE, 32'd0},
        '{OP_ADD, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_DONE, 32'd0},
        '{OP_ADD, 1'b1, 32'd0, 32'hA5A5_5A5A, 1'b1, ST_DONE, 32'd0},
        '{OP_ADD, 1'b1, 32'hFFFF_FFFF, 32'h5A5A_A5A5, 1'b1, ST_DONE, 32'd0},
        '{OP_SHOW, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b1, ST_DONE, 32'hFFFF_FFFF},
        '{OP_SHOW, 1'b1, 32'd0, 32'd0, 1'b1, ST_DONE, 32'hA5A5_5A5A},
        '{OP_ADD, 1'b0, 32'd0, 32'd77, 1'b0, ST_DONE, 32'd0},
        '{OP_REMOVE, 1'b0, 32'd0, 32'd0, 1'b0, ST_DONE, 32'd0},
        '{OP_SHOW, 1'b0, 32'd0, 32'd0, 1'b0, ST_DONE, 32'd0},
        '{OP_REMOVE, 1'b1, 32'd0, 32'd0, 1'b0, ST_DONE, 32'd0},
        '{OP_REMOVE, 1'b0, 32'd0, 32'd0, 1'b0, ST_DONE, 32'd0},
        '{OP_REMOVE, 1'b0, 32'd0, 32'd0, 1'b0, ST_DONE, 32'd0},
        '{OP_REMOVE, 1'b1, 32'd0, 32'd0, 1'b0, ST_DONE, 32'd0},
        '{OP_SHOW, 1'b0, 32'd0, 32'd0, 1'b1, ST_NONE, 32'd0}
    };

    initial begin
        logic s;
        t_op  op;
        int   n;
        errors = 0;
        results_seen = 0;
        cycles = 0;
        send_idle_pct = 24;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_func = FUNC_ADD;
        i_side = 1'b0;
        i_price = '0;
        i_order_handle = '0;
        for (int sd = 0; sd < 2; sd++)
            for (int i = 0; i < NLEV; i++) begin
                lvl_count[sd][i] = 0;
                lvl_head[sd][i] = 0;
                lvl_price[sd][i] = '0;
            end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (table_rows[r])
            send_request(table_rows[r].op, table_rows[r].side, table_rows[r].price,
                         table_rows[r].handle, table_rows[r].typed,
                         table_rows[r].status, table_rows[r].front);

        // One level filled past its depth, then the buy side past its level count.
        for (int i = 0; i <= NDEP; i++)
            send_request(OP_ADD, 1'b1, 32'd500, $urandom, 1'b0, ST_DONE, '0);
        for (int i = 0; i <= NLEV; i++)
            send_request(OP_ADD, 1'b0, 32'd2000 + i, $urandom, 1'b0, ST_DONE, '0);
        for (int i = 0; i < NLEV + NDEP + 4; i++)
            send_request(OP_REMOVE, i[0], '0, '0, 1'b0, ST_DONE, '0);
        used_prices[0] = {};
        used_prices[1] = {};

        for (int i = 0; i < RAND_REQS; i++) begin
            if (i == RAND_REQS / 3) send_idle_pct = 62;
            if (i == 2 * RAND_REQS / 3) send_idle_pct = 0;
            s = $urandom_range(1);
            n = $urandom_range(99);
            // Add-heavy and remove-heavy stretches so the book grows and drains.
            if (((i / 200) % 2) == 0) op = (n < 55) ? OP_ADD : (n < 75) ? OP_REMOVE
                                                   : (n < 97) ? OP_SHOW : OP_NOP;
            else op = (n < 25) ? OP_ADD : (n < 70) ? OP_REMOVE
                                        : (n < 97) ? OP_SHOW : OP_NOP;
            send_request(op, s, pick_price(s), $urandom, 1'b0, ST_DONE, '0);
            if (op == OP_ADD && used_prices[s].size() < 80)
                used_prices[s].push_back(i_price);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d requests over add, remove, show and unused codes on both sides;",
                 RAND_REQS + NLEV * 2 + NDEP * 2 + 24);
        $display("checked %0d results, book full and level full cases included.",
                 results_seen);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
